### design/lss_pkg.sv
// Shared types, sizes and codes for the LIFO stack with search.
package lss_pkg;

    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int OUT_CNT_W = 7;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Request from the sequencer to the entry memory.
    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } t_mem_req;

    // Finished result offered by the sequencer.
    typedef struct packed {
        logic                    valid;
        t_status                 status;
        logic                    found;
        logic [OUT_CNT_W-1:0]    position;
        logic                    is_empty;
        logic [OUT_CNT_W-1:0]    entry_count;
        logic signed [KEY_W-1:0] bottom_value;
    } t_result;

endpackage

### design/lss_mem.sv
// Entry memory: one write port and one registered read port.
module lss_mem (
    input  logic                                i_clk,
    input  lss_pkg::t_mem_req                   i_req,
    output logic [lss_pkg::KEY_W-1:0]           o_rdata
);

    logic [lss_pkg::KEY_W-1:0] r_mem [lss_pkg::DEPTH];
    logic [lss_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/lss_seq.sv
// Command sequencer: entry count, bottom entry and the one-compare-per-cycle search scan.
module lss_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_command,
    input  logic [lss_pkg::KEY_W-1:0]     i_value,
    output lss_pkg::t_mem_req             o_mem_req,
    input  logic [lss_pkg::KEY_W-1:0]     i_rdata,
    output lss_pkg::t_result              o_result,
    input  logic                          i_ack
);

    lss_pkg::t_state           r_state, n_state;
    logic [lss_pkg::CNT_W-1:0] r_count, n_count;
    logic [lss_pkg::KEY_W-1:0] r_bottom, n_bottom;
    logic [lss_pkg::KEY_W-1:0] r_key, n_key;
    logic [lss_pkg::PTR_W-1:0] r_idx, n_idx;
    logic [lss_pkg::CNT_W-1:0] r_left, n_left;
    logic [lss_pkg::CNT_W-1:0] r_pos, n_pos;
    logic                      r_pend, n_pend;
    logic                      r_found, n_found;
    lss_pkg::t_status          r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lss_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_bottom <= n_bottom;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_left   <= n_left;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_status <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_bottom  = r_bottom;
        n_key     = r_key;
        n_idx     = r_idx;
        n_left    = r_left;
        n_pos     = r_pos;
        n_pend    = 1'b0;
        n_found   = r_found;
        n_status  = r_status;
        o_ready   = 1'b0;
        o_mem_req = '0;

        case (r_state)
            lss_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_status = lss_pkg::ST_OK;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_state  = lss_pkg::S_DONE;
                    case (lss_pkg::t_cmd'(i_command))
                        lss_pkg::CMD_PUSH: begin
                            if (r_count == lss_pkg::CNT_W'(lss_pkg::DEPTH)) begin
                                n_status = lss_pkg::ST_PUSH_FULL;
                            end else begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = r_count[lss_pkg::PTR_W-1:0];
                                o_mem_req.wdata = i_value;
                                n_count         = r_count + 1'b1;
                                if (r_count == '0) begin
                                    n_bottom = i_value;
                                end
                            end
                        end
                        lss_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                n_status = lss_pkg::ST_POP_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        lss_pkg::CMD_SEARCH: begin
                            n_key = i_value;
                            if (r_count != '0) begin
                                n_idx   = lss_pkg::PTR_W'(r_count - 1'b1);
                                n_left  = r_count;
                                n_state = lss_pkg::S_SCAN;
                            end
                        end
                        lss_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = '0;
                        end
                    endcase
                end
            end

            lss_pkg::S_SCAN: begin
                // Issue reads top-down; each read is compared in the next cycle.
                if (r_left != '0) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_idx;
                    n_idx           = r_idx - 1'b1;
                    n_left          = r_left - 1'b1;
                    n_pend          = 1'b1;
                end
                if (r_pend) begin
                    n_pos = r_pos + 1'b1;
                    if (i_rdata == r_key) begin
                        n_found = 1'b1;
                        n_pend  = 1'b0;
                        n_state = lss_pkg::S_DONE;
                    end else if (r_left == '0) begin
                        n_state = lss_pkg::S_DONE;
                    end
                end
            end

            lss_pkg::S_DONE: begin
                if (i_ack) begin
                    n_state = lss_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lss_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.valid        = (r_state == lss_pkg::S_DONE);
        o_result.status       = r_status;
        o_result.found        = r_found;
        o_result.position     = r_found ? lss_pkg::OUT_CNT_W'(r_pos) : '0;
        o_result.is_empty     = (r_count == '0);
        o_result.entry_count  = lss_pkg::OUT_CNT_W'(r_count);
        o_result.bottom_value = (r_count == '0) ? '0 : $signed(r_bottom);
    end

endmodule

### design/lifo_stack_with_search.sv
// Top level of the LIFO stack with search: sequencer, entry memory and output register.
//
// The input channel (i_valid / o_ready) carries a command and a signed 32-bit value:
// push, pop, search or clear. Each input transfer yields exactly one result transfer
// on the output channel (o_valid / i_ready) with the status, search hit and position,
// and the empty flag, entry count and bottom entry as they stand after the command.
// The block works on one command at a time and holds o_ready low until the result
// has moved into the output register.
// Push, pop and clear go from the sequencer's done state into the output register,
// and the sequencer then returns to idle to take the next command.
// A search reads one stored entry per cycle from the top through the single read
// port of the entry memory and stops early at the first (newest) match, or after
// the bottom entry on a miss; a search of an empty stack skips the scan and goes
// straight to the result.
// When the receiver stalls, the finished result waits in the output register; the
// next command is still taken and worked on, and its result is held in the
// sequencer until the output register frees up.
// Synchronous reset empties the stack at once; stored entries need no clearing pass,
// since only entries below the count are ever read.
module lifo_stack_with_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic [6:0]         o_position,
    output logic               o_is_empty,
    output logic [6:0]         o_entry_count,
    output logic signed [31:0] o_bottom_value
);

    lss_pkg::t_mem_req         mem_req;
    logic [lss_pkg::KEY_W-1:0] mem_rdata;
    lss_pkg::t_result          result;
    logic                      take;

    logic                      r_out_valid;
    lss_pkg::t_result          r_out;

    lss_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .i_value   (i_value),
        .o_mem_req (mem_req),
        .i_rdata   (mem_rdata),
        .o_result  (result),
        .i_ack     (take)
    );

    lss_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // A finished result moves into the output register when it is empty or being drained.
    assign take = result.valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_found        = r_out.found;
    assign o_position     = r_out.position;
    assign o_is_empty     = r_out.is_empty;
    assign o_entry_count  = r_out.entry_count;
    assign o_bottom_value = r_out.bottom_value;

endmodule

### design/lss_checker.sv
// Port-level checks for the LIFO stack with search, bound to the top level.
module lss_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [1:0]         i_command,
    input logic signed [31:0] i_value,
    input logic               o_valid,
    input logic               i_ready,
    input logic [1:0]         o_status,
    input logic               o_found,
    input logic [6:0]         o_position,
    input logic               o_is_empty,
    input logic [6:0]         o_entry_count,
    input logic signed [31:0] o_bottom_value
);

    // One command at a time: the block is busy right after an input transfer.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again right after a transfer");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_position)
            && $stable(o_entry_count) && $stable(o_bottom_value))
        else $error("stalled result changed");

    // The empty flag, count and bottom entry agree.
    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == 7'd0))
            && (!o_is_empty || o_bottom_value == 32'sd0))
        else $error("empty flag, count and bottom entry disagree");

    // A hit always has a nonzero position; an error status never comes with a hit.
    a_found_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_found == (o_position != 7'd0)) && (o_status == 2'd0 || !o_found))
        else $error("search hit and position disagree");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (.*);

### bench/testbench.sv
// Self-checking testbench for the LIFO stack with search: directed and random tests.
`timescale 1ns / 100ps

// The bench keeps its own copy of the stack contents and fill level. Each command
// transfer on the input channel runs through a small predictor. The predictor
// stores the expected result in a queue of pending results. A separate process
// takes every result transfer on the output channel and checks it, field by field,
// against the oldest pending result.
//
// Stimulus runs as a chain of named tests, all called from one initial block:
//   - commands on an empty stack (pop underflow, search miss, clear),
//   - extreme keys, duplicate keys and search positions,
//   - filling the stack to the top, pushing on a full stack, and draining it,
//   - a long receiver hold-off while the sender keeps offering commands,
//   - random traffic in four idle/stall phases.
// A watchdog ends the run when no transfer happens on either channel for too long.
module testbench;

    import lss_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_PER_PHASE = 400;

    // The expected content of one result transfer.
    typedef struct {
        t_status                 status;
        logic                    found;
        logic [OUT_CNT_W-1:0]    position;
        logic                    is_empty;
        logic [OUT_CNT_W-1:0]    entry_count;
        logic signed [KEY_W-1:0] bottom_value;
    } t_stack_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_command = CMD_PUSH;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic               o_found;
    logic [6:0]         o_position;
    logic               o_is_empty;
    logic [6:0]         o_entry_count;
    logic signed [31:0] o_bottom_value;

    // Shadow copy of the stack: index 0 is the oldest entry.
    logic signed [KEY_W-1:0] stack_keys [DEPTH];
    int stack_fill = 0;

    t_stack_result pending_results [$];
    t_stack_result oldest_result;

    // Idle and stall rates in percent, set per test phase.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // The back-pressure test bumps hold_requests; the receiver notices and counts
    // its own hold-off down.
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int mismatch_count = 0;
    int results_checked = 0;
    int idle_cycles = 0;
    int push_total = 0, push_on_full = 0;
    int pop_total = 0, pop_on_empty = 0;
    int search_total = 0, search_hits = 0;
    int clear_total = 0;

    lifo_stack_with_search i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_position     (o_position),
        .o_is_empty     (o_is_empty),
        .o_entry_count  (o_entry_count),
        .o_bottom_value (o_bottom_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one command to the shadow stack and returns the result the block
    // must report for it. A search walks down from the top, so the first hit it
    // keeps is the newest copy of the key.
    function automatic t_stack_result apply_command(t_cmd cmd, logic signed [KEY_W-1:0] key);
        t_stack_result r;
        r.status   = ST_OK;
        r.found    = 1'b0;
        r.position = '0;
        case (cmd)
            CMD_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    r.status = ST_PUSH_FULL;
                end else begin
                    stack_keys[PTR_W'(stack_fill)] = key;
                    stack_fill++;
                end
            end
            CMD_POP: begin
                if (stack_fill == 0) begin
                    r.status = ST_POP_EMPTY;
                end else begin
                    stack_fill--;
                end
            end
            CMD_SEARCH: begin
                for (int i = stack_fill - 1; i >= 0; i--) begin
                    if (!r.found && stack_keys[PTR_W'(i)] == key) begin
                        r.found    = 1'b1;
                        r.position = OUT_CNT_W'(stack_fill - i);
                    end
                end
            end
            default: begin
                stack_fill = 0;
            end
        endcase
        r.is_empty     = (stack_fill == 0);
        r.entry_count  = OUT_CNT_W'(stack_fill);
        r.bottom_value = (stack_fill == 0) ? '0 : stack_keys[0];
        return r;
    endfunction

    // Offers one command and returns at the falling edge after its transfer.
    // Valid is left high so that the next command follows back to back unless
    // the sender decides to idle.
    task automatic send_command(t_cmd cmd, logic signed [KEY_W-1:0] key);
        t_stack_result r;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_command = cmd;
        i_value   = key;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        r = apply_command(cmd, key);
        pending_results.push_back(r);
        case (cmd)
            CMD_PUSH: begin
                push_total++;
                if (r.status == ST_PUSH_FULL) push_on_full++;
            end
            CMD_POP: begin
                pop_total++;
                if (r.status == ST_POP_EMPTY) pop_on_empty++;
            end
            CMD_SEARCH: begin
                search_total++;
                if (r.found) search_hits++;
            end
            default: clear_total++;
        endcase
        @(negedge i_clk);
    endtask

    // Some small keys so duplicates occur, some extremes, the rest (the majority) fully random.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return KEY_W'($signed($urandom_range(0, 7)) - 4);
        end else if (r < 40) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom();
    endfunction

    // Search keys are mostly taken from the stack itself so that hits land at
    // every depth.
    function automatic logic signed [KEY_W-1:0] pick_search_key();
        if (stack_fill > 0 && $urandom_range(0, 99) < 60) begin
            return stack_keys[PTR_W'($urandom_range(0, stack_fill - 1))];
        end
        return pick_key();
    endfunction

    task automatic wait_for_drain();
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Pop, search and clear on a stack that holds nothing.
    task automatic test_empty_stack();
        send_command(CMD_POP, 32'sd5);
        send_command(CMD_SEARCH, 32'sd0);
        send_command(CMD_CLEAR, -32'sd1);
    endtask

    // Extreme keys, a duplicate, hits at the top, in the middle and at the bottom,
    // and a miss.
    task automatic test_key_extremes();
        send_command(CMD_PUSH, 32'sh8000_0000);
        send_command(CMD_PUSH, 32'sh7FFF_FFFF);
        send_command(CMD_PUSH, 32'sd0);
        send_command(CMD_PUSH, -32'sd1);
        send_command(CMD_PUSH, 32'sd0);
        send_command(CMD_SEARCH, 32'sh8000_0000);
        send_command(CMD_SEARCH, 32'sh7FFF_FFFF);
        send_command(CMD_SEARCH, 32'sd0);
        send_command(CMD_SEARCH, -32'sd1);
        send_command(CMD_SEARCH, 32'sd1);
        send_command(CMD_POP, 32'sd0);
        send_command(CMD_SEARCH, 32'sd0);
        send_command(CMD_CLEAR, 32'sd0);
        send_command(CMD_SEARCH, 32'sh7FFF_FFFF);
    endtask

    // Fill to DEPTH with keys that are unique in their low bits, overflow twice,
    // search the whole depth, then pop one past empty.
    task automatic test_fill_and_overflow();
        logic signed [KEY_W-1:0] bottom_key;
        bottom_key = ($urandom() & 32'hFFFF_FF80);
        send_command(CMD_PUSH, bottom_key);
        for (int i = 1; i < DEPTH; i++) begin
            send_command(CMD_PUSH, ($urandom() & 32'hFFFF_FF80) | i);
        end
        send_command(CMD_PUSH, $urandom());
        send_command(CMD_PUSH, $urandom());
        send_command(CMD_SEARCH, bottom_key);
        send_command(CMD_SEARCH, ($urandom() & 32'hFFFF_FF80) | 32'h7F);
        send_command(CMD_SEARCH, stack_keys[DEPTH-1]);
        for (int i = 0; i <= DEPTH; i++) begin
            send_command(CMD_POP, $urandom());
        end
    endtask

    // The receiver holds off for a long stretch while commands keep coming, so
    // the output register and the sequencer fill up and the input stalls.
    task automatic test_back_pressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_requests++;
        for (int i = 0; i < 16; i++) begin
            if (i % 3 == 2) begin
                send_command(CMD_SEARCH, pick_search_key());
            end else begin
                send_command(CMD_PUSH, pick_key());
            end
        end
    endtask

    // Random traffic in runs that grow, shrink or mix, with some fully random
    // commands mixed in. Growing runs push the stack toward full, shrinking runs
    // toward empty.
    task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
        int run_kind;
        int r;
        int push_lim, pop_lim, search_lim;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        run_kind = 0;
        for (int n = 0; n < n_items; n++) begin
            if (n % 48 == 0) begin
                run_kind = $urandom_range(0, 2);
            end
            case (run_kind)
                0: begin push_lim = 70; pop_lim = 82; search_lim = 99; end
                1: begin push_lim = 25; pop_lim = 75; search_lim = 98; end
                default: begin push_lim = 42; pop_lim = 70; search_lim = 97; end
            endcase
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 8) begin
                send_command(t_cmd'($urandom_range(0, 3)), $urandom());
            end else if (r < push_lim) begin
                send_command(CMD_PUSH, pick_key());
            end else if (r < pop_lim) begin
                send_command(CMD_POP, pick_key());
            end else if (r < search_lim) begin
                send_command(CMD_SEARCH, pick_search_key());
            end else begin
                send_command(CMD_CLEAR, pick_key());
            end
        end
    endtask

    // Receiver: ready is redrawn at each falling edge, unless a hold-off runs.
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else begin
            i_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic compare_field(string field, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected 'h%0h, actual 'h%0h", field, expected, actual);
            mismatch_count++;
        end
    endtask

    // Every result transfer is checked against the oldest pending result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no command outstanding");
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                compare_field("status", oldest_result.status, o_status);
                compare_field("found", oldest_result.found, o_found);
                compare_field("position", oldest_result.position, o_position);
                compare_field("is_empty", oldest_result.is_empty, o_is_empty);
                compare_field("entry_count", oldest_result.entry_count, o_entry_count);
                compare_field("bottom_value", oldest_result.bottom_value, o_bottom_value);
            end
        end
    end

    // A search ends after at most DEPTH reads, and the long hold-off is far
    // shorter than the limit, so only a hung block reaches it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("No transfer for %0d cycles, giving up", WATCHDOG_LIMIT);
                $display("lifo_stack_with_search regression: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_stack();
        test_key_extremes();
        sender_idle_pct = 10;
        recv_stall_pct  = 10;
        test_fill_and_overflow();
        test_back_pressure();
        test_random_traffic(RANDOM_PER_PHASE, 0, 0);
        test_random_traffic(RANDOM_PER_PHASE, 76, 0);
        test_random_traffic(RANDOM_PER_PHASE, 0, 76);
        test_random_traffic(RANDOM_PER_PHASE, 10, 10);

        i_valid = 1'b0;
        wait_for_drain();
        // Let any stray result show up before the verdict.
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("Ran %0d pushes (%0d on a full stack), %0d pops (%0d on an empty stack),",
                 push_total, push_on_full, pop_total, pop_on_empty);
        $display("%0d clears and %0d searches (%0d hits); %0d results checked, %0d mismatches",
                 clear_total, search_total, search_hits, results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("lifo_stack_with_search regression: pass");
        end else begin
            $display("lifo_stack_with_search regression: fail");
        end
        $finish;
    end

endmodule
